@@ hw/rtl/dqe_pkg.sv @@
// ----------------------------------------------------------------------------
// dqe_pkg
// shared types, command and status codes for the double-ended queue
// ----------------------------------------------------------------------------
package dqe_pkg;

   localparam int VALUE_WIDTH      = 32;
   localparam int DEFAULT_CAPACITY = 32;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;

   // command codes
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd1;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_LIST_FWD   = 3'd4;
   localparam logic [2:0] CMD_LIST_BWD   = 3'd5;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // operation broadcast to every cell of the chain
   typedef enum logic [2:0] {
      OP_HOLD      = 3'd0,
      OP_SHIFT_IN  = 3'd1,
      OP_SHIFT_OUT = 3'd2,
      OP_APPEND    = 3'd3,
      OP_DROP_BACK = 3'd4,
      OP_ROT_FWD   = 3'd5,
      OP_ROT_BWD   = 3'd6
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      value_type   value;
   } cell_ctrl_type;

endpackage

@@ hw/rtl/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// push/pop: one word per cycle while the output slot is free, result in the
//    next cycle; listing: words out of the list state, one per cycle while
//    the output slot is free, input stalled while the chain rotates
// reset clears the occupied flags and the entry count, stored words are kept
// a bounded deque in a chain of cells; when idle, the front entry is in cell 0
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int CAPACITY = dqe_pkg::DEFAULT_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   // command channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_cmd,
   input  dqe_pkg::value_type req_push_value,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dqe_pkg::value_type rsp_out_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_last_of_run
);
   import dqe_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LIST = 2'b10
   } state_type;

   // controller state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] left_ff, left_in;     // words still to list
   logic             dir_bwd_ff, dir_bwd_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   value_type  rsp_value_ff, rsp_value_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic       rsp_last_ff, rsp_last_in;

   // chain signals
   cell_ctrl_type ctrl;
   value_type     cell_value [CAPACITY];
   logic          cell_occ   [CAPACITY];
   value_type     cell_tap   [CAPACITY];
   value_type     back_value;
   value_type     head_feed;
   logic          out_free;
   logic          accept;
   logic          is_full;
   logic          is_empty;

   // output slot can take a new word when empty or being drained
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) | ~out_free;
   assign accept    = req_valid & ~req_stall;

   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // back word: only the last occupied cell drives its tap
   always_comb begin
      back_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         back_value = back_value | cell_tap[i];
      end
   end

   // cell 0 takes the push word, or the back word when rotating backward
   assign head_feed = (ctrl.op == OP_ROT_BWD) ? back_value : req_push_value;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      left_in       = left_ff;
      dir_bwd_in    = dir_bwd_ff;
      ctrl.op       = OP_HOLD;
      ctrl.value    = req_push_value;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = req_push_value;
                     rsp_last_in  = 1'b1;
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        rsp_status_in = STATUS_OK;
                        count_in      = count_ff + 1'b1;
                        ctrl.op       = (req_cmd == CMD_PUSH_FRONT) ? OP_SHIFT_IN : OP_APPEND;
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     if (is_empty) begin
                        rsp_value_in  = '0;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        rsp_status_in = STATUS_OK;
                        count_in      = count_ff - 1'b1;
                        if (req_cmd == CMD_POP_FRONT) begin
                           rsp_value_in = cell_value[0];
                           ctrl.op      = OP_SHIFT_OUT;
                        end else begin
                           rsp_value_in = back_value;
                           ctrl.op      = OP_DROP_BACK;
                        end
                     end
                  end
                  CMD_LIST_FWD, CMD_LIST_BWD: begin
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_status_in = STATUS_EMPTY;
                        rsp_last_in   = 1'b1;
                     end else begin
                        state_in   = ST_LIST;
                        left_in    = count_ff;
                        dir_bwd_in = (req_cmd == CMD_LIST_BWD);
                     end
                  end
                  default: begin
                     // unused codes are swallowed without a result
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LIST: begin
            // one word per free output slot; a full turn restores the order
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = dir_bwd_ff ? back_value : cell_value[0];
               rsp_status_in = STATUS_OK;
               rsp_last_in   = (left_ff == CNT_W'(1));
               ctrl.op       = dir_bwd_ff ? OP_ROT_BWD : OP_ROT_FWD;
               left_in       = left_ff - 1'b1;
               if (left_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // the chain, front at cell 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      value_type lv, rv;
      logic      lo, ro;
      if (i == 0) begin : g_head
         assign lv = head_feed;
         assign lo = 1'b1;
      end else begin : g_body
         assign lv = cell_value[i-1];
         assign lo = cell_occ[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign rv = '0;
         assign ro = 1'b0;
      end else begin : g_inner
         assign rv = cell_value[i+1];
         assign ro = cell_occ[i+1];
      end
      dqe_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_value  (lv),
         .left_occ    (lo),
         .right_value (rv),
         .right_occ   (ro),
         .front_value (cell_value[0]),
         .value       (cell_value[i]),
         .occ         (cell_occ[i]),
         .back_tap    (cell_tap[i])
      );
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      left_ff       <= left_in;
      dir_bwd_ff    <= dir_bwd_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

@@ hw/rtl/dqe_cell.sv @@
// ----------------------------------------------------------------------------
// dqe_cell
// one slot of the deque chain: a word and an occupied flag
// ----------------------------------------------------------------------------
module dqe_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  dqe_pkg::cell_ctrl_type ctrl,
   input  dqe_pkg::value_type    left_value,
   input  logic                  left_occ,
   input  dqe_pkg::value_type    right_value,
   input  logic                  right_occ,
   input  dqe_pkg::value_type    front_value,
   output dqe_pkg::value_type    value,
   output logic                  occ,
   output dqe_pkg::value_type    back_tap
);
   import dqe_pkg::*;

   value_type value_ff, value_in;
   logic      occ_ff, occ_in;
   logic      is_last;
   logic      is_first_free;

   assign is_last       = occ_ff & ~right_occ;
   assign is_first_free = ~occ_ff & left_occ;

   always_comb begin
      value_in = value_ff;
      occ_in   = occ_ff;
      case (ctrl.op)
         OP_SHIFT_IN: begin
            value_in = left_value;
            occ_in   = left_occ;
         end
         OP_SHIFT_OUT: begin
            value_in = right_value;
            occ_in   = right_occ;
         end
         OP_APPEND: begin
            if (is_first_free) begin
               value_in = ctrl.value;
               occ_in   = 1'b1;
            end
         end
         OP_DROP_BACK: begin
            if (is_last) begin
               occ_in = 1'b0;
            end
         end
         // front word wraps around to the back slot
         OP_ROT_FWD: begin
            if (occ_ff) begin
               value_in = is_last ? front_value : right_value;
            end
         end
         OP_ROT_BWD: begin
            if (occ_ff) begin
               value_in = left_value;
            end
         end
         default: begin
            value_in = value_ff;
            occ_in   = occ_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign value    = value_ff;
   assign occ      = occ_ff;
   assign back_tap = is_last ? value_ff : '0;

endmodule

@@ hw/rtl/dqe_checker.sv @@
// ----------------------------------------------------------------------------
// dqe_checker
// port-level checks for the double-ended queue, bound to the top level
// ----------------------------------------------------------------------------
module dqe_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input dqe_pkg::value_type rsp_out_value,
   input logic [1:0]         rsp_status,
   input logic               rsp_last_of_run
);
   import dqe_pkg::*;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_value)
         && $stable(rsp_status) && $stable(rsp_last_of_run))
      else $error("stalled result word changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // empty and full answers stand alone
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_last_of_run)
      else $error("error status without end-of-run mark");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_out_value == '0)
      else $error("empty answer with nonzero word");

   // a full output slot always pushes back on the command side
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("command taken while result slot blocked");

endmodule

bind double_ended_queue dqe_checker u_dqe_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_value   (rsp_out_value),
   .rsp_status      (rsp_status),
   .rsp_last_of_run (rsp_last_of_run)
);
